/* rtl/core/dss_pkg.sv */
// Shared types and constants for the disk seek scheduler.
package dss_pkg;

    localparam int CYL_W  = 12;
    localparam int KIND_W = 2;
    localparam int DIST_W = 18;
    localparam int MODE_W = 2;
    localparam int CIDX_W = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = 18'h3FFFF;

    localparam int MAX_REQUESTS_DEF = 16;

    localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

    localparam logic [KIND_W-1:0] KIND_HEAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOUND = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_UPPER = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_LOWER = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RST  = MODE_FCFS;
    localparam logic [CYL_W-1:0]  UPPER_RST = 12'd199;
    localparam logic [CYL_W-1:0]  LOWER_RST = 12'd0;

    typedef struct packed {
        logic [CYL_W-1:0] cyl;
        logic [CYL_W-1:0] head;
        logic             last;
    } t_req;

endpackage

/* rtl/core/dss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/dss_front.sv */
// Front end: two-entry request queue between the input port and the walker.
module dss_front import dss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CYL_W-1:0] i_cyl,
    input  logic [CYL_W-1:0] i_head,
    input  logic             i_last,
    output logic             o_q_valid,
    output t_req             o_q,
    input  logic             i_q_pop
);
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{cyl: i_cyl, head: i_head, last: i_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

/* rtl/core/dss_back.sv */
// Back end: request store, sweep searches and the result stream.
module dss_back import dss_pkg::*; #(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_req              i_q,
    output logic              o_q_pop,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [CYL_W-1:0]  i_upper,
    input  logic [CYL_W-1:0]  i_lower,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CYL_W-1:0]  o_cyl,
    output logic [KIND_W-1:0] o_kind,
    output logic [DIST_W-1:0] o_dist,
    output logic              o_last
);
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int KW = CYL_W + IW;
    localparam int LW = KW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_REQUESTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_FADDR = 3'd2;
    localparam logic [2:0] S_FEMIT = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_SNEXT = 3'd5;
    localparam logic [2:0] S_UPB   = 3'd6;
    localparam logic [2:0] S_LOWB  = 3'd7;

    localparam logic [1:0] PH_CNT = 2'd0;
    localparam logic [1:0] PH_UP  = 2'd1;
    localparam logic [1:0] PH_LO  = 2'd2;

    logic [2:0]        r_st;
    logic [1:0]        r_ph;
    logic [CW-1:0]     r_cnt, r_n, r_split, r_rem, r_si, r_fi;
    logic [CYL_W-1:0]  r_head, r_cur;
    logic [DIST_W-1:0] r_sum;
    logic              r_cv, r_found, r_fmax;
    logic [IW-1:0]     r_ci;
    logic [KW-1:0]     r_best;
    logic [LW-1:0]     r_lo, r_hi;

    logic              r_ov, r_olast;
    logic [CYL_W-1:0]  r_ocyl;
    logic [KIND_W-1:0] r_okind;

    logic [CYL_W-1:0]  rd_data;
    logic [IW-1:0]     rd_addr;
    logic              we;

    logic              e_go, e_last, fire, out_free;
    logic [CYL_W-1:0]  e_cyl, d;
    logic [KIND_W-1:0] e_kind;
    logic [DIST_W:0]   sum_w;
    logic [DIST_W-1:0] n_sum;
    logic [LW-1:0]     key, head_key, best_inc;
    logic              in_win, better;

    assign o_q_pop  = (r_st == S_IDLE) && i_q_valid;
    assign we       = o_q_pop && (r_cnt < MAXC);
    assign rd_addr  = (r_st == S_SCAN) ? r_si[IW-1:0] : r_fi[IW-1:0];
    assign head_key = {1'b0, r_head, {IW{1'b0}}};
    assign best_inc = {1'b0, r_best} + LW'(1);

    dss_ram #(.WIDTH(CYL_W), .DEPTH(MAX_REQUESTS), .AW(IW)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (i_q.cyl),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // window compare; ties broken by arrival index
    assign key    = {1'b0, rd_data, r_ci};
    assign in_win = (key >= r_lo) && (key < r_hi);
    assign better = !r_found || (r_fmax ? (key[KW-1:0] > r_best) : (key[KW-1:0] < r_best));

    always_comb begin
        e_go   = 1'b0;
        e_cyl  = r_head;
        e_kind = KIND_HEAD;
        e_last = 1'b0;
        unique case (r_st)
            S_HEAD: begin
                e_go = 1'b1;
            end
            S_FEMIT: begin
                e_go   = 1'b1;
                e_cyl  = rd_data;
                e_kind = KIND_REQ;
                e_last = (r_fi == r_n - CW'(1));
            end
            S_SNEXT: begin
                e_go   = (r_ph != PH_CNT);
                e_cyl  = r_best[KW-1:IW];
                e_kind = KIND_REQ;
                e_last = (r_rem == CW'(1)) && ((r_ph == PH_LO) || (r_split == '0));
            end
            S_UPB: begin
                e_go   = 1'b1;
                e_cyl  = i_upper;
                e_kind = KIND_BOUND;
            end
            S_LOWB: begin
                e_go   = 1'b1;
                e_cyl  = i_lower;
                e_kind = KIND_BOUND;
            end
            default: begin
                e_go = 1'b0;
            end
        endcase
    end

    assign out_free = !r_ov || !i_stall;
    assign fire     = e_go && out_free;
    assign d        = (e_cyl > r_cur) ? (e_cyl - r_cur) : (r_cur - e_cyl);
    assign sum_w    = {1'b0, r_sum} + (DIST_W+1)'(d);
    assign n_sum    = (e_kind == KIND_HEAD) ? '0 :
                      (sum_w > {1'b0, DIST_MAX}) ? DIST_MAX : sum_w[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ocyl  <= e_cyl;
            r_okind <= e_kind;
            r_olast <= e_last;
            r_sum   <= n_sum;
            r_cur   <= e_cyl;
        end
        if (o_q_pop && i_q.last) begin
            r_head <= i_q.head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_ph    <= PH_CNT;
            r_cnt   <= '0;
            r_n     <= '0;
            r_split <= '0;
            r_rem   <= '0;
            r_si    <= '0;
            r_fi    <= '0;
            r_cv    <= 1'b0;
            r_ci    <= '0;
            r_found <= 1'b0;
            r_fmax  <= 1'b0;
            r_best  <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (fire) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_st)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (r_cnt < MAXC) r_cnt <= r_cnt + CW'(1);
                        if (i_q.last) begin
                            r_n   <= r_cnt + CW'(r_cnt < MAXC);
                            r_cnt <= '0;
                            r_st  <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    if (fire) begin
                        r_fi <= '0;
                        if (i_mode == MODE_SCAN || i_mode == MODE_CSCAN) begin
                            r_ph    <= PH_CNT;
                            r_lo    <= '0;
                            r_hi    <= head_key;
                            r_split <= '0;
                            r_fmax  <= 1'b0;
                            r_si    <= '0;
                            r_cv    <= 1'b0;
                            r_found <= 1'b0;
                            r_st    <= S_SCAN;
                        end else begin
                            r_st <= S_FADDR;
                        end
                    end
                end
                S_FADDR: begin
                    r_st <= S_FEMIT;
                end
                S_FEMIT: begin
                    if (fire) begin
                        if (e_last) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_fi <= r_fi + CW'(1);
                            r_st <= S_FADDR;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cv && in_win) begin
                        if (r_ph == PH_CNT) r_split <= r_split + CW'(1);
                        if (better) begin
                            r_found <= 1'b1;
                            r_best  <= key[KW-1:0];
                        end
                    end
                    r_cv <= (r_si < r_n);
                    r_ci <= r_si[IW-1:0];
                    if (r_si < r_n) r_si <= r_si + CW'(1);
                    if (r_si == r_n && !r_cv) r_st <= S_SNEXT;
                end
                S_SNEXT: begin
                    priority if (r_ph == PH_CNT) begin
                        if (r_n != r_split) begin
                            r_ph    <= PH_UP;
                            r_rem   <= r_n - r_split;
                            r_lo    <= head_key;
                            r_hi    <= '1;
                            r_fmax  <= 1'b0;
                            r_si    <= '0;
                            r_cv    <= 1'b0;
                            r_found <= 1'b0;
                            r_st    <= S_SCAN;
                        end else begin
                            r_st <= S_UPB;
                        end
                    end else if (fire) begin
                        r_rem <= r_rem - CW'(1);
                        if (r_rem == CW'(1)) begin
                            r_st <= (r_ph == PH_UP && r_split != '0) ? S_UPB : S_IDLE;
                        end else begin
                            if (r_fmax) r_hi <= {1'b0, r_best};
                            else        r_lo <= best_inc;
                            r_si    <= '0;
                            r_cv    <= 1'b0;
                            r_found <= 1'b0;
                            r_st    <= S_SCAN;
                        end
                    end
                end
                S_UPB, S_LOWB: begin
                    if (fire) begin
                        if (r_st == S_UPB && i_mode == MODE_CSCAN) begin
                            r_st <= S_LOWB;
                        end else begin
                            r_ph    <= PH_LO;
                            r_rem   <= r_split;
                            r_lo    <= '0;
                            r_hi    <= head_key;
                            r_fmax  <= (i_mode == MODE_SCAN);
                            r_si    <= '0;
                            r_cv    <= 1'b0;
                            r_found <= 1'b0;
                            r_st    <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_cyl   = r_ocyl;
    assign o_kind  = r_okind;
    assign o_dist  = r_sum;
    assign o_last  = r_olast;
endmodule

/* rtl/core/disk_seek_scheduler.sv */
// Top level of the disk seek scheduler: config registers, front queue, back walker.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | i_in_valid/o_in_stall | request_cylinder, head_position, batch_end
//  out     | output    | o_out_valid/i_out_stall | visited_cylinder, visit_kind, distance, end
//  cfg     | input     | i_cfg_valid/o_cfg_ready | cfg_index, cfg_data
//
// A request transfer is stored in the front queue first, then written to the store. On the batch end
// the walker emits the head, then each served request: FCFS sets up a store read and then emits
// its result (registered read data); sweep modes first count requests below the head in one pass
// over the store and then decide, then run one min/max search pass per served request and emit its
// result; bound points are emitted as their own results.
// Reset is synchronous, active low, and clears all control state; the store needs no clearing.
// A stalled output holds the walk; the front queue keeps taking transfers until it is full.
module disk_seek_scheduler import dss_pkg::*; #(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CYL_W-1:0]  i_request_cylinder,
    input  logic [CYL_W-1:0]  i_head_position,
    input  logic              i_batch_end,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CYL_W-1:0]  o_visited_cylinder,
    output logic [KIND_W-1:0] o_visit_kind,
    output logic [DIST_W-1:0] o_total_distance,
    output logic              o_order_end,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CYL_W-1:0]  i_cfg_data
);
    logic [MODE_W-1:0] r_mode;
    logic [CYL_W-1:0]  r_upper, r_lower;
    logic              q_valid, q_pop;
    t_req              q_data;

    assign o_cfg_ready = 1'b1;

    // config writes are always taken; the host must write only while no batch is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RST;
            r_upper <= UPPER_RST;
            r_lower <= LOWER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_UPPER: r_upper <= i_cfg_data;
                CFG_LOWER: r_lower <= i_cfg_data;
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    dss_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_cyl     (i_request_cylinder),
        .i_head    (i_head_position),
        .i_last    (i_batch_end),
        .o_q_valid (q_valid),
        .o_q       (q_data),
        .i_q_pop   (q_pop)
    );

    dss_back #(.MAX_REQUESTS(MAX_REQUESTS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q       (q_data),
        .o_q_pop   (q_pop),
        .i_mode    (r_mode),
        .i_upper   (r_upper),
        .i_lower   (r_lower),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_cyl     (o_visited_cylinder),
        .o_kind    (o_visit_kind),
        .o_dist    (o_total_distance),
        .o_last    (o_order_end)
    );
endmodule
